### design/iasrt_pkg.sv
// Package for the integer array sorter: sizes, item structs, queue entry and FSM state.
// No dependencies.
package iasrt_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic                    last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_result;
        logic                    items_dropped;
    } t_out_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    store;
        logic                    last;
    } t_entry;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

### design/iasrt_front.sv
// Front end: accepts input items, tags each as stored or dropped, and queues it.
// Depends on iasrt_pkg.
module iasrt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iasrt_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output iasrt_pkg::t_entry o_q_entry
);
    import iasrt_pkg::*;

    t_entry           r_q [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_fill, n_fill;
    logic [CNT_W-1:0] r_set_cnt, n_set_cnt;
    logic             push, pop;
    t_entry           w_entry;

    assign o_in_ready = (r_fill != 2'd2);
    assign o_q_valid  = (r_fill != 2'd0);
    assign o_q_entry  = r_q[r_rp];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    always_comb begin
        w_entry.value = i_in_item.item_value;
        w_entry.store = (r_set_cnt < CNT_W'(MAX_ITEMS));
        w_entry.last  = i_in_item.last_item;
        n_set_cnt     = r_set_cnt;
        if (push) begin
            if (i_in_item.last_item) begin
                n_set_cnt = '0;
            end else if (w_entry.store) begin
                n_set_cnt = r_set_cnt + CNT_W'(1);
            end
        end
        n_wp   = push ? ~r_wp : r_wp;
        n_rp   = pop ? ~r_rp : r_rp;
        n_fill = r_fill + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_fill    <= 2'd0;
            r_set_cnt <= '0;
        end else begin
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_fill    <= n_fill;
            r_set_cnt <= n_set_cnt;
        end
    end

endmodule

### design/iasrt_back.sv
// Back end: insertion chain of sorted cells, emission sequencer and output register.
// Depends on iasrt_pkg.
module iasrt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  iasrt_pkg::t_entry    i_q_entry,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iasrt_pkg::t_out_item o_out_item
);
    import iasrt_pkg::*;

    logic signed [VAL_W-1:0] r_cell [MAX_ITEMS];
    logic signed [VAL_W-1:0] n_cell [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]    gt;
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic                    r_ovf, n_ovf;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;
    logic                    pop, slot_free;

    // cells at or above the count act as empty (greater than anything)
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            gt[i] = (CNT_W'(i) >= r_cnt) || (r_cell[i] > i_q_entry.value);
        end
    end

    assign o_q_ready   = (r_state == ST_LOAD);
    assign pop         = i_q_valid && o_q_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_ovf       = r_ovf;
        n_cell      = r_cell;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_LOAD: begin
                if (pop) begin
                    if (i_q_entry.store) begin
                        for (int i = 0; i < MAX_ITEMS; i++) begin
                            if (gt[i]) begin
                                if (i == 0) begin
                                    n_cell[i] = i_q_entry.value;
                                end else if (!gt[i-1]) begin
                                    n_cell[i] = i_q_entry.value;
                                end else begin
                                    n_cell[i] = r_cell[i-1];
                                end
                            end
                        end
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_q_entry.last) begin
                        n_rem   = i_q_entry.store ? r_cnt + CNT_W'(1) : r_cnt;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out.sorted_value  = r_cell[0];
                    n_out.last_result   = (r_rem == CNT_W'(1));
                    n_out.items_dropped = (r_rem == CNT_W'(1)) && r_ovf;
                    n_out_valid         = 1'b1;
                    for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                        n_cell[i] = r_cell[i+1];
                    end
                    n_rem = r_rem - CNT_W'(1);
                    if (r_rem == CNT_W'(1)) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/integer_array_sorter_core.sv
// Top level of the integer array sorter: front end, two-entry queue, insertion-chain back end.
// Depends on iasrt_pkg, iasrt_front, iasrt_back.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// Each element enters the insertion chain when the back end takes it, so a set streams in
// at one item per cycle while loading. An item marked last starts emission: one result per
// stored element per cycle from the chain head; the queue accepts up to two items meanwhile.
// Reset (synchronous, active low) empties the queue and clears count and drop flag.
// Output stalls hold the result register and pause emission; input is not blocked by them
// until the queue fills.
module integer_array_sorter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  iasrt_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iasrt_pkg::t_out_item o_out_item
);
    import iasrt_pkg::*;

    logic   q_valid;
    logic   q_ready;
    t_entry q_entry;

    iasrt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_entry  (q_entry)
    );

    iasrt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_entry   (q_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
